[hw/rtl/integer_to_ascii_formatter_top_assert.svh]
// Assertion macros for the integer formatter checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// Check the consequence in the cycle after the trigger.
`define ITAF_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

// Check the consequence in the same cycle as the trigger.
`define ITAF_ASSERT_NOW(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error(msg);

`endif

[hw/rtl/itaf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

  localparam int VALUE_W         = 32;
  localparam int RADIX_W         = 5;
  localparam int FIELD_W         = 6;
  localparam int FLAGS_W         = 7;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;
  localparam int BITS_PER_STEP   = 8;
  localparam int STEPS_PER_DIGIT = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W          = $clog2(STEPS_PER_DIGIT);

  localparam int FLG_ZERO   = 0;
  localparam int FLG_SIGNED = 1;
  localparam int FLG_PLUS   = 2;
  localparam int FLG_SPACE  = 3;
  localparam int FLG_LEFT   = 4;
  localparam int FLG_LOWER  = 5;
  localparam int FLG_PREFIX = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 8'h37;
  localparam logic [CHAR_W-1:0] CH_UPPER_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_CASE_BIT   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MAX        = 8'h7A;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic pad;
    logic bound;
    logic emit;
  } itaf_cmd_t;

  typedef struct packed {
    logic bad_radix;
    logic digit_done;
    logic more_digits;
    logic gen_ready;
    logic gen_last;
  } itaf_sts_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d,
                                              input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_ALPHA_BASE + {4'd0, d};
    end
    return lower ? (c | CH_CASE_BIT) : c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/itaf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module itaf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/itaf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module itaf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itaf_pkg::itaf_sts_t sts,
  output itaf_pkg::itaf_cmd_t cmd
);

  import itaf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_BOUND = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          // drop an item with a bad radix
          if (!sts.bad_radix) begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.digit_done && !sts.more_digits) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_PAD;
      end
      S_PAD: begin
        cmd.pad    = 1'b1;
        state_next = S_BOUND;
      end
      S_BOUND: begin
        cmd.bound  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.gen_ready) begin
          cmd.emit = 1'b1;
          if (sts.gen_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/itaf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module itaf_datapath #(
  parameter int MAX_DIGITS = 32,
  parameter int MAX_FIELD  = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  itaf_pkg::itaf_cmd_t            cmd,
  output itaf_pkg::itaf_sts_t            sts,
  input  logic [itaf_pkg::VALUE_W-1:0]   value,
  input  logic [itaf_pkg::RADIX_W-1:0]   radix,
  input  logic [itaf_pkg::FIELD_W-1:0]   field_width,
  input  logic [itaf_pkg::FIELD_W-1:0]   min_digits,
  input  logic [itaf_pkg::FLAGS_W-1:0]   format_flags,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [itaf_pkg::CHAR_W-1:0]    character,
  output logic                           last_char
);

  import itaf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int POS_W  = $clog2(MAX_FIELD + MAX_DIGITS + 4);

  localparam logic [FIELD_W-1:0] FIELD_MAX = FIELD_W'(MAX_FIELD);
  localparam logic [CNT_W-1:0]   CNT_STOP  = CNT_W'(MAX_DIGITS - 1);
  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(STEPS_PER_DIGIT - 1);

  // item context
  logic [RADIX_W-1:0] radix_r;
  logic [FIELD_W-1:0] fw_r;
  logic [FIELD_W-1:0] md_r;
  logic               zero_eff;
  logic               left;
  logic               lower;
  logic               sign_on;
  logic [CHAR_W-1:0]  sign_char;
  logic [1:0]         pre_len;

  // digit extraction
  logic [VALUE_W-1:0]       quo;
  logic [VALUE_W-1:0]       quo_next;
  logic [DIGIT_W-1:0]       rem;
  logic [DIGIT_W-1:0]       div_r;
  logic [DIGIT_W:0]         div_t;
  logic [BITS_PER_STEP-1:0] div_qb;
  logic [STEP_W-1:0]        step_cnt;
  logic [CNT_W-1:0]         dig_cnt;

  // field layout
  logic [POS_W-1:0] prec;
  logic [1:0]       hdr;
  logic [POS_W-1:0] lead;
  logic [POS_W-1:0] lead_v;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] b_lead;
  logic [POS_W-1:0] b_sign;
  logic [POS_W-1:0] b_p0;
  logic [POS_W-1:0] b_px;
  logic [POS_W-1:0] b_prec;
  logic [POS_W-1:0] b_dig;
  logic [POS_W-1:0] b_lead_v;
  logic [POS_W-1:0] b_dig_v;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] dix;

  // character generation
  logic              gen_digit;
  logic [CHAR_W-1:0] gen_char;
  logic              b_valid;
  logic              b_digit;
  logic              b_last;
  logic              b_lower;
  logic [CHAR_W-1:0] b_char;
  logic              o_ready;
  logic              b_ready;
  logic [DIGIT_W-1:0] rd_data;
  logic              digit_wr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r  <= radix;
      fw_r     <= (field_width > FIELD_MAX) ? FIELD_MAX : field_width;
      md_r     <= (min_digits > FIELD_MAX) ? FIELD_MAX : min_digits;
      zero_eff <= format_flags[FLG_ZERO] & ~format_flags[FLG_LEFT];
      left     <= format_flags[FLG_LEFT];
      lower    <= format_flags[FLG_LOWER];
      sign_on  <= format_flags[FLG_SIGNED] & (value[VALUE_W-1] | format_flags[FLG_PLUS] |
                                              format_flags[FLG_SPACE]);
      sign_char <= value[VALUE_W-1] ? CH_MINUS :
                   (format_flags[FLG_PLUS] ? CH_PLUS : CH_SPACE);
      if (!format_flags[FLG_PREFIX]) begin
        pre_len <= 2'd0;
      end else if (radix == RADIX_OCT) begin
        pre_len <= 2'd1;
      end else if (radix == RADIX_HEX) begin
        pre_len <= 2'd2;
      end else begin
        pre_len <= 2'd0;
      end
    end
  end

  // eight restoring steps, most significant bit first
  always_comb begin
    div_r  = rem;
    div_t  = '0;
    div_qb = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      div_t = {div_r, quo[VALUE_W-1-i]};
      if (div_t >= radix_r) begin
        div_t                       = div_t - radix_r;
        div_qb[BITS_PER_STEP-1-i]   = 1'b1;
      end
      div_r = div_t[DIGIT_W-1:0];
    end
  end

  assign quo_next = {quo[VALUE_W-BITS_PER_STEP-1:0], div_qb};
  assign digit_wr = cmd.step && (step_cnt == STEP_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= (format_flags[FLG_SIGNED] && value[VALUE_W-1]) ?
                  (VALUE_W'(0) - value) : value;
      rem      <= '0;
      step_cnt <= '0;
      dig_cnt  <= '0;
    end else if (cmd.step) begin
      quo <= quo_next;
      if (step_cnt == STEP_LAST) begin
        rem      <= '0;
        step_cnt <= '0;
        dig_cnt  <= dig_cnt + CNT_W'(1);
      end else begin
        rem      <= div_r;
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

  assign lead_v   = POS_W'(hdr) + prec;
  assign b_lead_v = (!zero_eff && !left) ? pad : '0;
  assign b_dig_v  = (left ? POS_W'(0) : pad) + lead;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prec <= (POS_W'(md_r) > POS_W'(dig_cnt)) ? POS_W'(md_r) : POS_W'(dig_cnt);
      hdr  <= {1'b0, sign_on} + pre_len;
    end
    if (cmd.pad) begin
      lead <= lead_v;
      pad  <= (POS_W'(fw_r) > lead_v) ? (POS_W'(fw_r) - lead_v) : '0;
    end
    if (cmd.bound) begin
      total  <= pad + lead;
      b_lead <= b_lead_v;
      b_sign <= b_lead_v + POS_W'(sign_on);
      b_p0   <= b_lead_v + POS_W'(sign_on) + POS_W'(pre_len != 2'd0);
      b_px   <= b_lead_v + POS_W'(hdr);
      b_dig  <= b_dig_v;
      b_prec <= b_dig_v - POS_W'(dig_cnt);
      pos    <= '0;
    end else if (cmd.emit) begin
      pos <= pos + POS_W'(1);
    end
  end

  assign dix = b_dig - POS_W'(1) - pos;

  always_comb begin
    gen_digit = 1'b0;
    gen_char  = CH_SPACE;
    if (pos < b_lead) begin
      gen_char = CH_SPACE;
    end else if (pos < b_sign) begin
      gen_char = sign_char;
    end else if (pos < b_p0) begin
      gen_char = CH_ZERO;
    end else if (pos < b_px) begin
      gen_char = lower ? (CH_UPPER_X | CH_CASE_BIT) : CH_UPPER_X;
    end else if (pos < b_prec) begin
      gen_char = CH_ZERO;
    end else if (pos < b_dig) begin
      gen_digit = 1'b1;
    end else begin
      gen_char = CH_SPACE;
    end
  end

  itaf_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (digit_wr),
    .wr_addr (dig_cnt[ADDR_W-1:0]),
    .wr_data (div_r),
    .rd_en   (cmd.emit),
    .rd_addr (dix[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign o_ready = !out_valid || !out_stall;
  assign b_ready = !b_valid || o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        b_valid <= 1'b1;
      end else if (o_ready) begin
        b_valid <= 1'b0;
      end
      if (o_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      b_digit <= gen_digit;
      b_char  <= gen_char;
      b_last  <= (pos == total - POS_W'(1));
      b_lower <= lower;
    end
    if (o_ready && b_valid) begin
      character <= b_digit ? glyph(rd_data, b_lower) : b_char;
      last_char <= b_last;
    end
  end

  assign sts.bad_radix   = (radix < RADIX_MIN) || (radix > RADIX_HEX);
  assign sts.digit_done  = (step_cnt == STEP_LAST);
  assign sts.more_digits = (quo_next != '0) && (dig_cnt < CNT_STOP);
  assign sts.gen_ready   = b_ready;
  assign sts.gen_last    = (pos == total - POS_W'(1));

endmodule

`default_nettype wire

[hw/rtl/integer_to_ascii_formatter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake           Payload
// input    in_valid/in_stall   value, radix, field_width, min_digits, format_flags
// output   out_valid/out_stall character, last_char
//
// One item at a time. The restoring divider extracts digits at 8 quotient bits a
// cycle, then the layout states prep, pad and bound run, then characters go out
// at one per cycle while the output is not stalled.
// An item with a radix outside 2..16 is taken and gives nothing.
// Synchronous reset clears the controller and output valid; no clearing pass.
// Output stall holds the output register; the generator stage fills behind it.

module integer_to_ascii_formatter_top #(
  parameter int MAX_DIGITS = 32,
  parameter int MAX_FIELD  = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [itaf_pkg::VALUE_W-1:0] value,
  input  logic [itaf_pkg::RADIX_W-1:0] radix,
  input  logic [itaf_pkg::FIELD_W-1:0] field_width,
  input  logic [itaf_pkg::FIELD_W-1:0] min_digits,
  input  logic [itaf_pkg::FLAGS_W-1:0] format_flags,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [itaf_pkg::CHAR_W-1:0]  character,
  output logic                         last_char
);

  import itaf_pkg::*;

  itaf_cmd_t cmd;
  itaf_sts_t sts;

  itaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itaf_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .radix        (radix),
    .field_width  (field_width),
    .min_digits   (min_digits),
    .format_flags (format_flags),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .character    (character),
    .last_char    (last_char)
  );

endmodule

`default_nettype wire

[hw/rtl/itaf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_formatter_top_assert.svh"

module itaf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [itaf_pkg::RADIX_W-1:0] radix,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [itaf_pkg::CHAR_W-1:0]  character,
  input logic                         last_char
);

  import itaf_pkg::*;

  `ITAF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(character) && $stable(last_char), "stalled output item changed")
  `ITAF_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall && radix >= RADIX_MIN && radix <= RADIX_HEX, in_stall, "input not stalled after taking an item")
  `ITAF_ASSERT_NEXT(a_drop_bad_radix, in_valid && !in_stall && (radix < RADIX_MIN || radix > RADIX_HEX), !in_stall, "item with bad radix not dropped")
  `ITAF_ASSERT_NOW(a_char_range, out_valid, character >= CH_SPACE && character <= CH_MAX, "character outside the printable set")

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .radix     (radix),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .character (character),
  .last_char (last_char)
);

`default_nettype wire
